### src/sbag_pkg.sv
package sbag_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_WIDTH  = 3'd0,
    REG_TARGET_HEIGHT = 3'd1,
    REG_CLIP_LEFT     = 3'd2,
    REG_CLIP_TOP      = 3'd3,
    REG_CLIP_WIDTH    = 3'd4,
    REG_CLIP_HEIGHT   = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam int unsigned RST_TARGET_WIDTH  = 320;
  localparam int unsigned RST_TARGET_HEIGHT = 240;
  localparam int unsigned RST_CLIP_LEFT     = 0;
  localparam int unsigned RST_CLIP_TOP      = 0;
  localparam int unsigned RST_CLIP_WIDTH    = 320;
  localparam int unsigned RST_CLIP_HEIGHT   = 240;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;    // latch start request, launch step division
    logic advance;  // emit next pair and advance raster position
    logic mul;      // form clipped-offset products
    logic finish;   // form start positions, load start result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

### src/sbag_div.sv
module sbag_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit a cycle; dividend bits shift out
  // of the top of the quotient register as quotient bits shift in.
  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == CNT_W'(NUM_W - 1));
  // Zero divisor gives a zero quotient
  assign quo_o  = (den_q == '0) ? '0 : quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

### src/sbag_ctrl.sv
module sbag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  input  logic              out_ready_i,
  input  sbag_pkg::status_t status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output sbag_pkg::cmd_t    cmd_o
);

  sbag_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  // Take a request only when idle and the output slot is free or draining
  assign in_ready_o  = (state_q == sbag_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbag_pkg::ST_IDLE: begin
        if (accept && (in_action_i == sbag_pkg::ACT_START)) begin
          state_d = sbag_pkg::ST_DIV;
        end
      end
      sbag_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = sbag_pkg::ST_MUL;
        end
      end
      sbag_pkg::ST_MUL: begin
        state_d = sbag_pkg::ST_SUM;
      end
      sbag_pkg::ST_SUM: begin
        state_d = sbag_pkg::ST_IDLE;
      end
      default: begin
        state_d = sbag_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      sbag_pkg::ST_IDLE: begin
        cmd_o.start   = accept && (in_action_i == sbag_pkg::ACT_START);
        cmd_o.advance = accept && (in_action_i == sbag_pkg::ACT_NEXT);
      end
      sbag_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      sbag_pkg::ST_SUM: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.advance || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbag_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The start result lands in an output slot that is always empty
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_valid_q)
    else $error("start result loaded over a pending result");

  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == sbag_pkg::ST_DIV))
    else $error("start request did not launch the division");

  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbag_pkg::ST_DIV) && status_i.div_done |=> (state_q == sbag_pkg::ST_MUL))
    else $error("division completion missed");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sbag_pkg::ST_IDLE) |-> !(cmd_o.start || cmd_o.advance))
    else $error("request taken while a start is in progress");

endmodule

### src/sbag_dp.sv
module sbag_dp #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbag_pkg::cmd_t                      cmd_i,
  output sbag_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_BITS:0]                 cfg_data_i,
  input  logic [COORD_BITS-1:0]               from_x_i,
  input  logic [COORD_BITS-1:0]               from_y_i,
  input  logic [COORD_BITS:0]                 from_width_i,
  input  logic [COORD_BITS:0]                 from_height_i,
  input  logic signed [COORD_BITS:0]          to_x_i,
  input  logic signed [COORD_BITS:0]          to_y_i,
  input  logic [COORD_BITS:0]                 to_width_i,
  input  logic [COORD_BITS:0]                 to_height_i,
  output logic                                pair_valid_o,
  output logic [COORD_BITS:0]                 sample_x_o,
  output logic [COORD_BITS:0]                 sample_y_o,
  output logic [COORD_BITS-1:0]               write_x_o,
  output logic [COORD_BITS-1:0]               write_y_o,
  output logic                                inside_clip_o,
  output logic                                final_pair_o
);

  localparam int unsigned W = COORD_BITS + 1;              // wide coordinate
  localparam int unsigned S = COORD_BITS + 1 + FRAC_BITS;  // step
  localparam int unsigned P = COORD_BITS + 2 + FRAC_BITS;  // position
  localparam logic [W-1:0] TGT_MAX = W'(1) << COORD_BITS;

  // Configuration registers
  logic [W-1:0] tgt_w_q, tgt_h_q, clip_l_q, clip_t_q, clip_w_q, clip_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_w_q  <= W'(sbag_pkg::RST_TARGET_WIDTH);
      tgt_h_q  <= W'(sbag_pkg::RST_TARGET_HEIGHT);
      clip_l_q <= W'(sbag_pkg::RST_CLIP_LEFT);
      clip_t_q <= W'(sbag_pkg::RST_CLIP_TOP);
      clip_w_q <= W'(sbag_pkg::RST_CLIP_WIDTH);
      clip_h_q <= W'(sbag_pkg::RST_CLIP_HEIGHT);
    end else if (cfg_we_i) begin
      case (sbag_pkg::reg_idx_e'(cfg_index_i))
        sbag_pkg::REG_TARGET_WIDTH:  tgt_w_q  <= cfg_data_i;
        sbag_pkg::REG_TARGET_HEIGHT: tgt_h_q  <= cfg_data_i;
        sbag_pkg::REG_CLIP_LEFT:     clip_l_q <= cfg_data_i;
        sbag_pkg::REG_CLIP_TOP:      clip_t_q <= cfg_data_i;
        sbag_pkg::REG_CLIP_WIDTH:    clip_w_q <= cfg_data_i;
        sbag_pkg::REG_CLIP_HEIGHT:   clip_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Clip both destination axes against the capped target size
  logic [W-1:0]          tgt_w_cap, tgt_h_cap;
  logic signed [W+1:0]   hi_x, hi_y, hic_x, hic_y, lo_x, lo_y;
  logic [W-1:0]          skx, sky;
  logic                  empty;

  assign tgt_w_cap = (tgt_w_q > TGT_MAX) ? TGT_MAX : tgt_w_q;
  assign tgt_h_cap = (tgt_h_q > TGT_MAX) ? TGT_MAX : tgt_h_q;

  always_comb begin
    hi_x  = $signed({{2{to_x_i[W-1]}}, to_x_i}) + $signed({2'b00, to_width_i});
    hi_y  = $signed({{2{to_y_i[W-1]}}, to_y_i}) + $signed({2'b00, to_height_i});
    hic_x = (hi_x > $signed({2'b00, tgt_w_cap})) ? $signed({2'b00, tgt_w_cap}) : hi_x;
    hic_y = (hi_y > $signed({2'b00, tgt_h_cap})) ? $signed({2'b00, tgt_h_cap}) : hi_y;
    lo_x  = to_x_i[W-1] ? '0 : $signed({2'b00, to_x_i});
    lo_y  = to_y_i[W-1] ? '0 : $signed({2'b00, to_y_i});
    // Negate the origin to count the skipped columns and rows
    skx   = to_x_i[W-1] ? (~to_x_i + 1'b1) : '0;
    sky   = to_y_i[W-1] ? (~to_y_i + 1'b1) : '0;
    empty = (to_width_i == '0) || (to_height_i == '0) || (hic_x <= lo_x) || (hic_y <= lo_y);
  end

  // Latched start request
  logic [COORD_BITS-1:0] fx_q, fy_q;
  logic [W-1:0]          x0_q, x1_q, y0_q, y1_q, skx_q, sky_q;
  logic                  empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fx_q    <= from_x_i;
      fy_q    <= from_y_i;
      x0_q    <= lo_x[W-1:0];
      x1_q    <= hic_x[W-1:0];
      y0_q    <= lo_y[W-1:0];
      y1_q    <= hic_y[W-1:0];
      skx_q   <= skx;
      sky_q   <= sky;
      empty_q <= empty;
    end
  end

  // Step sizes: source size over destination size
  logic [S-1:0] step_x, step_y;
  logic         done_y;

  sbag_div #(
    .NUM_W (S),
    .DEN_W (W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   ({from_width_i, {FRAC_BITS{1'b0}}}),
    .den_i   (to_width_i),
    .done_o  (status_o.div_done),
    .quo_o   (step_x)
  );

  sbag_div #(
    .NUM_W (S),
    .DEN_W (W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   ({from_height_i, {FRAC_BITS{1'b0}}}),
    .den_i   (to_height_i),
    .done_o  (done_y),
    .quo_o   (step_y)
  );

  // Offset of the first visible pixel in source space
  logic [W+S-1:0] mul_x, mul_y;
  logic [P-1:0]   prod_x_q, prod_y_q;

  assign mul_x = skx_q * step_x;
  assign mul_y = sky_q * step_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_x_q <= mul_x[P-1:0];
      prod_y_q <= mul_y[P-1:0];
    end
  end

  // Raster walk state
  logic         active_q, active_d;
  logic [W-1:0] col_q, col_d, row_q, row_d;
  logic [W-1:0] col_begin_q, col_begin_d, col_end_q, col_end_d, row_end_q, row_end_d;
  logic [P-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_xb_q, pos_xb_d;
  logic [W-1:0] col_inc, row_inc;
  logic [W:0]   clip_r, clip_b;
  logic         in_clip;

  logic               pair_valid_q, pair_valid_d;
  logic [W-1:0]       sample_x_q, sample_x_d, sample_y_q, sample_y_d;
  logic [W-2:0]       write_x_q, write_x_d, write_y_q, write_y_d;
  logic               inside_q, inside_d, final_q, final_d;

  assign col_inc = col_q + 1'b1;
  assign row_inc = row_q + 1'b1;
  assign clip_r  = {1'b0, clip_l_q} + {1'b0, clip_w_q};
  assign clip_b  = {1'b0, clip_t_q} + {1'b0, clip_h_q};
  assign in_clip = ({1'b0, col_q} >= {1'b0, clip_l_q}) && ({1'b0, col_q} < clip_r) &&
                   ({1'b0, row_q} >= {1'b0, clip_t_q}) && ({1'b0, row_q} < clip_b);

  always_comb begin
    active_d     = active_q;
    col_d        = col_q;
    row_d        = row_q;
    col_begin_d  = col_begin_q;
    col_end_d    = col_end_q;
    row_end_d    = row_end_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    pos_xb_d     = pos_xb_q;
    pair_valid_d = pair_valid_q;
    sample_x_d   = sample_x_q;
    sample_y_d   = sample_y_q;
    write_x_d    = write_x_q;
    write_y_d    = write_y_q;
    inside_d     = inside_q;
    final_d      = final_q;
    if (cmd_i.finish) begin
      // Start position at the center of the first visible pixel
      pos_xb_d     = P'({fx_q, {FRAC_BITS{1'b0}}}) + prod_x_q + P'(step_x[S-1:1]);
      pos_x_d      = pos_xb_d;
      pos_y_d      = P'({fy_q, {FRAC_BITS{1'b0}}}) + prod_y_q + P'(step_y[S-1:1]);
      col_d        = x0_q;
      col_begin_d  = x0_q;
      col_end_d    = x1_q;
      row_d        = y0_q;
      row_end_d    = y1_q;
      active_d     = !empty_q;
      pair_valid_d = 1'b0;
      sample_x_d   = '0;
      sample_y_d   = '0;
      write_x_d    = '0;
      write_y_d    = '0;
      inside_d     = 1'b0;
      final_d      = empty_q;
    end else if (cmd_i.advance) begin
      pair_valid_d = active_q;
      sample_x_d   = active_q ? pos_x_q[FRAC_BITS +: W] : '0;
      sample_y_d   = active_q ? pos_y_q[FRAC_BITS +: W] : '0;
      write_x_d    = active_q ? col_q[W-2:0] : '0;
      write_y_d    = active_q ? row_q[W-2:0] : '0;
      inside_d     = active_q && in_clip;
      final_d      = active_q && (col_inc >= col_end_q) && (row_inc >= row_end_q);
      if (active_q) begin
        col_d   = col_inc;
        pos_x_d = pos_x_q + P'(step_x);
        // Wrap to the start of the next row
        if (col_inc >= col_end_q) begin
          col_d   = col_begin_q;
          pos_x_d = pos_xb_q;
          row_d   = row_inc;
          pos_y_d = pos_y_q + P'(step_y);
          if (row_inc >= row_end_q) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    row_q        <= row_d;
    col_begin_q  <= col_begin_d;
    col_end_q    <= col_end_d;
    row_end_q    <= row_end_d;
    pos_x_q      <= pos_x_d;
    pos_y_q      <= pos_y_d;
    pos_xb_q     <= pos_xb_d;
    pair_valid_q <= pair_valid_d;
    sample_x_q   <= sample_x_d;
    sample_y_q   <= sample_y_d;
    write_x_q    <= write_x_d;
    write_y_q    <= write_y_d;
    inside_q     <= inside_d;
    final_q      <= final_d;
  end

  assign pair_valid_o  = pair_valid_q;
  assign sample_x_o    = sample_x_q;
  assign sample_y_o    = sample_y_q;
  assign write_x_o     = write_x_q;
  assign write_y_o     = write_y_q;
  assign inside_clip_o = inside_q;
  assign final_pair_o  = final_q;

  // Both dividers run the same number of iterations
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.div_done == done_y)
    else $error("step dividers out of step");

  a_advance_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance && !active_q |=> !pair_valid_q && !final_q)
    else $error("idle next request produced a pair");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !$past(cmd_i.finish) |-> (col_q < col_end_q) && (row_q < row_end_q))
    else $error("raster position ran past the clipped range");

endmodule

### src/scaled_blit_address_generator.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    tdata: start rectangles, tuser: action
// m_axis    out        m_axis_tvalid/m_axis_tready    tdata: coordinates, tuser/tlast: flags
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// A next request is answered in the cycle after acceptance; requests follow
// each other every cycle as long as the output register drains. A start
// request runs the two step divisions in parallel, one quotient bit a
// cycle; its result then passes through a multiply state and an add state
// before it is registered. Reset restores the register defaults and leaves
// the block idle; no clearing pass. A stalled output holds its result, and
// s_axis_tready drops until the held result is taken.
module scaled_blit_address_generator #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // from_x, from_y, from_width, from_height, to_x, to_y, to_width, to_height
  input  logic [((8*COORD_BITS+6+7)/8)*8-1:0]    s_axis_tdata,
  // action
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // sample_x, sample_y, write_x, write_y
  output logic [((4*COORD_BITS+2+7)/8)*8-1:0]    m_axis_tdata,
  // pair_valid, inside_clip
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COORD_BITS:0]                    cfg_data_i
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned W      = COORD_BITS + 1;
  localparam int unsigned OUT_TW = ((4*COORD_BITS+2+7)/8)*8;

  // Unpack the start request, lowest field first
  logic [C-1:0]        from_x, from_y;
  logic [W-1:0]        from_width, from_height, to_width, to_height;
  logic signed [W-1:0] to_x, to_y;

  assign from_x      = s_axis_tdata[0 +: C];
  assign from_y      = s_axis_tdata[C +: C];
  assign from_width  = s_axis_tdata[2*C +: W];
  assign from_height = s_axis_tdata[2*C+W +: W];
  assign to_x        = s_axis_tdata[2*C+2*W +: W];
  assign to_y        = s_axis_tdata[2*C+3*W +: W];
  assign to_width    = s_axis_tdata[2*C+4*W +: W];
  assign to_height   = s_axis_tdata[2*C+5*W +: W];

  // Register writes are taken at any time
  assign cfg_ready_o = 1'b1;

  sbag_pkg::cmd_t    cmd;
  sbag_pkg::status_t status;

  logic         pair_valid, inside_clip, final_pair;
  logic [W-1:0] sample_x, sample_y;
  logic [C-1:0] write_x, write_y;

  sbag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  sbag_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .from_x_i      (from_x),
    .from_y_i      (from_y),
    .from_width_i  (from_width),
    .from_height_i (from_height),
    .to_x_i        (to_x),
    .to_y_i        (to_y),
    .to_width_i    (to_width),
    .to_height_i   (to_height),
    .pair_valid_o  (pair_valid),
    .sample_x_o    (sample_x),
    .sample_y_o    (sample_y),
    .write_x_o     (write_x),
    .write_y_o     (write_y),
    .inside_clip_o (inside_clip),
    .final_pair_o  (final_pair)
  );

  // Pack the result, zero-filled to whole bytes
  assign m_axis_tdata = OUT_TW'({write_y, write_x, sample_y, sample_x});
  assign m_axis_tuser = {inside_clip, pair_valid};
  assign m_axis_tlast = final_pair;

endmodule
